FILE: hw/rtl/gatp_pkg.sv
// shared types and constants for the glyph atlas text placer
package gatp_pkg;

    localparam int TableDepth = 256;
    localparam int TableAw    = (TableDepth > 1) ? $clog2(TableDepth) : 1;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_CURSOR = 2'd1,
        FUNC_PLACE  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        CFG_BASE_CODE     = 2'd0,
        CFG_CHARS_PER_ROW = 2'd1,
        CFG_CELL_WIDTH    = 2'd2,
        CFG_CELL_HEIGHT   = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_EMIT
    } top_state_t;

    typedef enum logic [2:0] {
        U_IDLE,
        U_DIV,
        U_MULX,
        U_MULY,
        U_DONE
    } unit_state_t;

    typedef struct packed {
        logic       start;
        logic [7:0] idx;
        logic [7:0] divisor;
        logic [9:0] cell_w;
        logic [9:0] cell_h;
    } unit_ctrl_t;

    typedef struct packed {
        logic        done;
        logic [15:0] atlas_x;
        logic [15:0] atlas_y;
    } unit_stat_t;

endpackage

FILE: hw/rtl/glyph_atlas_text_placer.sv
// top level of the glyph atlas text placer
//
// Input beats load an advance width, set the pen, or place a character. Load
// and set-pen beats give no output beat. A placed character whose code is at
// or above the base code passes through the shared unit (one bit of the 8-step
// restoring divide per cycle, then the shared multiplier for each of the two
// atlas products) before its output beat; one below the base goes straight to
// its output beat. The input side is not ready while a character is being
// worked on; a finished output beat waits in an output register, so the next
// input beat is taken while it waits. Width entries come from a 256 x 8 ram
// that is not cleared; placing a code whose entry was never loaded gives an
// unspecified advance.
module glyph_atlas_text_placer (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // char_code, advance_value, start_x, start_y
    input  logic [1:0]  s_axis_tuser,  // func

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // screen_x, screen_y, atlas_x, atlas_y
    output logic [0:0]  m_axis_tuser,  // below_base

    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [9:0]  cfg_wdata
);

    gatp_pkg::top_state_t state_reg, state_next;
    gatp_pkg::func_t      func;
    gatp_pkg::unit_ctrl_t unit_ctrl;
    gatp_pkg::unit_stat_t unit_stat;

    logic [7:0]  base_code_reg;
    logic [7:0]  chars_per_row_reg;
    logic [9:0]  cell_width_reg;
    logic [9:0]  cell_height_reg;

    logic [15:0] pen_x_reg;
    logic [15:0] pen_y_reg;
    logic [7:0]  code_reg;
    logic        below_reg;

    logic        m_valid_reg;
    logic [63:0] m_data_reg;
    logic        m_below_reg;

    logic [7:0]  char_code;
    logic [7:0]  advance_value;
    logic [15:0] start_x;
    logic [15:0] start_y;

    logic        accept;
    logic        below;
    logic        in_table;
    logic        code_in_table;
    logic        emit_load;
    logic [7:0]  adv_rdata;
    logic [7:0]  adv_w;
    logic [15:0] atlas_x;
    logic [15:0] atlas_y;

    assign func          = gatp_pkg::func_t'(s_axis_tuser);
    assign char_code     = s_axis_tdata[7:0];
    assign advance_value = s_axis_tdata[15:8];
    assign start_x       = s_axis_tdata[31:16];
    assign start_y       = s_axis_tdata[47:32];

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign below         = (char_code < base_code_reg);
    assign in_table      = ({1'b0, char_code} < 9'(gatp_pkg::TableDepth));
    assign code_in_table = ({1'b0, code_reg} < 9'(gatp_pkg::TableDepth));

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_code_reg     <= 8'd32;
            chars_per_row_reg <= 8'd16;
            cell_width_reg    <= 10'd16;
            cell_height_reg   <= 10'd16;
        end
        else if (cfg_we)
        begin
            unique case (gatp_pkg::cfg_idx_t'(cfg_addr))
                gatp_pkg::CFG_BASE_CODE:     base_code_reg     <= cfg_wdata[7:0];
                gatp_pkg::CFG_CHARS_PER_ROW: chars_per_row_reg <= cfg_wdata[7:0];
                gatp_pkg::CFG_CELL_WIDTH:    cell_width_reg    <= cfg_wdata;
                gatp_pkg::CFG_CELL_HEIGHT:   cell_height_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // advance width table
    gatp_ram #(
        .WIDTH (8),
        .DEPTH (gatp_pkg::TableDepth)
    ) u_adv_ram (
        .clk   (clk),
        .we    (accept && func == gatp_pkg::FUNC_LOAD && in_table),
        .waddr (char_code[gatp_pkg::TableAw-1:0]),
        .wdata (advance_value),
        .raddr (code_reg[gatp_pkg::TableAw-1:0]),
        .rdata (adv_rdata)
    );

    assign adv_w = code_in_table ? adv_rdata : 8'd0;

    // divide and multiply unit
    assign unit_ctrl.start   = accept && func == gatp_pkg::FUNC_PLACE && !below;
    assign unit_ctrl.idx     = char_code - base_code_reg;
    assign unit_ctrl.divisor = chars_per_row_reg;
    assign unit_ctrl.cell_w  = cell_width_reg;
    assign unit_ctrl.cell_h  = cell_height_reg;

    gatp_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (unit_ctrl),
        .stat  (unit_stat)
    );

    assign atlas_x = below_reg ? 16'd0 : unit_stat.atlas_x;
    assign atlas_y = below_reg ? 16'd0 : unit_stat.atlas_y;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gatp_pkg::S_IDLE:
            begin
                if (accept && func == gatp_pkg::FUNC_PLACE)
                begin
                    state_next = below ? gatp_pkg::S_EMIT : gatp_pkg::S_CALC;
                end
            end
            gatp_pkg::S_CALC:
            begin
                if (unit_stat.done)
                begin
                    state_next = gatp_pkg::S_EMIT;
                end
            end
            gatp_pkg::S_EMIT:
            begin
                if (emit_load)
                begin
                    state_next = gatp_pkg::S_IDLE;
                end
            end
            default: state_next = gatp_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        emit_load     = 1'b0;
        unique case (state_reg)
            gatp_pkg::S_IDLE: s_axis_tready = 1'b1;
            gatp_pkg::S_CALC: ;
            gatp_pkg::S_EMIT: emit_load = !m_valid_reg || m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= gatp_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
            pen_x_reg   <= 16'd0;
            pen_y_reg   <= 16'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (accept && func == gatp_pkg::FUNC_CURSOR)
            begin
                pen_x_reg <= start_x;
                pen_y_reg <= start_y;
            end
            else if (emit_load && !below_reg)
            begin
                pen_x_reg <= pen_x_reg + {8'd0, adv_w};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            code_reg  <= char_code;
            below_reg <= below;
        end
        if (emit_load)
        begin
            m_data_reg  <= {atlas_y, atlas_x, pen_y_reg, pen_x_reg};
            m_below_reg <= below_reg;
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_data_reg;
    assign m_axis_tuser[0] = m_below_reg;

    // the shared unit only finishes while the sequencer waits for it
    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        unit_stat.done |-> state_reg == gatp_pkg::S_CALC)
        else $error("unit finished outside calc state");

    // a placed character blocks the input side on the next cycle
    a_place_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func == gatp_pkg::FUNC_PLACE) |=> !s_axis_tready)
        else $error("input ready right after a place beat");

    // a character below the base carries a zero atlas origin
    a_below_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tdata[63:32] == 32'd0)
        else $error("below-base beat with nonzero atlas origin");

endmodule

FILE: hw/rtl/gatp_ram.sv
// generic single write port ram with registered read
module gatp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/gatp_unit.sv
// shared divide and multiply unit: restoring divide then two products
module gatp_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gatp_pkg::unit_ctrl_t ctrl,
    output gatp_pkg::unit_stat_t stat
);

    gatp_pkg::unit_state_t state_reg, state_next;

    logic [2:0]  cnt_reg, cnt_next;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  quo_reg, quo_next;
    logic [15:0] ax_reg, ax_next;
    logic [15:0] ay_reg, ay_next;

    logic        div_en;
    logic        mulx_en;
    logic        muly_en;
    logic        done;

    logic [8:0]  trial;
    logic        ge;
    logic [8:0]  diff;
    logic [17:0] mul_a;
    logic [17:0] mul_b;
    logic [17:0] prod;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gatp_pkg::U_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = gatp_pkg::U_DIV;
                end
            end
            gatp_pkg::U_DIV:
            begin
                if (cnt_reg == 3'd7)
                begin
                    state_next = gatp_pkg::U_MULX;
                end
            end
            gatp_pkg::U_MULX: state_next = gatp_pkg::U_MULY;
            gatp_pkg::U_MULY: state_next = gatp_pkg::U_DONE;
            gatp_pkg::U_DONE: state_next = gatp_pkg::U_IDLE;
            default:          state_next = gatp_pkg::U_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        div_en  = 1'b0;
        mulx_en = 1'b0;
        muly_en = 1'b0;
        done    = 1'b0;
        unique case (state_reg)
            gatp_pkg::U_IDLE: ;
            gatp_pkg::U_DIV:  div_en  = 1'b1;
            gatp_pkg::U_MULX: mulx_en = 1'b1;
            gatp_pkg::U_MULY: muly_en = 1'b1;
            gatp_pkg::U_DONE: done    = 1'b1;
            default: ;
        endcase
    end

    // restoring divide step: quotient bits shift in as dividend bits shift out
    assign trial = {rem_reg, quo_reg[7]};
    assign ge    = (trial >= {1'b0, ctrl.divisor});
    assign diff  = trial - {1'b0, ctrl.divisor};

    // one multiplier shared by both products: column then row
    assign mul_a = mulx_en ? {10'd0, rem_reg} : {10'd0, quo_reg};
    assign mul_b = mulx_en ? {8'd0, ctrl.cell_w} : {8'd0, ctrl.cell_h};
    assign prod  = mul_a * mul_b;

    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        ax_next  = ax_reg;
        ay_next  = ay_reg;
        if (state_reg == gatp_pkg::U_IDLE && ctrl.start)
        begin
            cnt_next = 3'd0;
            rem_next = 8'd0;
            quo_next = ctrl.idx;
        end
        if (div_en)
        begin
            cnt_next = cnt_reg + 3'd1;
            rem_next = ge ? diff[7:0] : trial[7:0];
            quo_next = {quo_reg[6:0], ge};
        end
        if (mulx_en)
        begin
            ax_next = prod[15:0];
        end
        if (muly_en)
        begin
            ay_next = prod[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gatp_pkg::U_IDLE;
            cnt_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ax_reg  <= ax_next;
        ay_reg  <= ay_next;
    end

    assign stat.done    = done;
    assign stat.atlas_x = ax_reg;
    assign stat.atlas_y = ay_reg;

endmodule
